@@ src/sle_pkg.sv @@
`timescale 1ns / 1ps

package sle_pkg;

	// Default list depth
	localparam int Capacity = 16;

	// Fixed field widths
	localparam int ValueW  = 32;
	localparam int CountW  = 5;
	localparam int OpW     = 2;
	localparam int StatusW = 2;

	typedef logic [OpW-1:0]     op_t;
	typedef logic [StatusW-1:0] status_t;

	// Operation codes
	localparam op_t OpInsert = 2'd0;
	localparam op_t OpAppend = 2'd1;
	localparam op_t OpDelete = 2'd2;
	localparam op_t OpDump   = 2'd3;

	// Status codes
	localparam status_t StOk       = 2'd0;
	localparam status_t StNotFound = 2'd1;
	localparam status_t StFull     = 2'd2;
	localparam status_t StEmpty    = 2'd3;

endpackage

@@ src/sle_ifs.sv @@
`timescale 1ns / 1ps

// Command channel: one operation per item
interface sle_cmd_if;
	logic                             valid;
	logic                             ready;
	sle_pkg::op_t                     operation;
	logic signed [sle_pkg::ValueW-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

// Response channel: one or more items per command
interface sle_rsp_if;
	logic                              valid;
	logic                              ready;
	sle_pkg::status_t                  status;
	logic signed [sle_pkg::ValueW-1:0] entry_value;
	logic                              is_last;
	logic [sle_pkg::CountW-1:0]        entry_count;

	modport source (output valid, output status, output entry_value, output is_last,
		output entry_count, input ready);
	modport sink   (input valid, input status, input entry_value, input is_last,
		input entry_count, output ready);
endinterface

@@ src/sle_mem.sv @@
`timescale 1ns / 1ps

// Entry storage: one write port, one read port, registered read data
module sle_mem #(
	parameter int DEPTH = sle_pkg::Capacity,
	parameter int WIDTH = sle_pkg::ValueW,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/sle_ctrl.sv @@
`timescale 1ns / 1ps

// Sequencer: scans, shifts and dumps the entry memory one access at a time
module sle_ctrl #(
	parameter int CAPACITY = sle_pkg::Capacity,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sle_cmd_if.sink                    cmd,
	sle_rsp_if.source                  rsp,
	output logic                       mem_wr_en,
	output logic [AW-1:0]              mem_wr_addr,
	output logic [sle_pkg::ValueW-1:0] mem_wr_data,
	output logic                       mem_rd_en,
	output logic [AW-1:0]              mem_rd_addr,
	input  logic [sle_pkg::ValueW-1:0] mem_rd_data
);

	localparam int CntOutW = sle_pkg::CountW;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RESULT   = 4'd1;
	localparam logic [3:0] S_SCAN_RD  = 4'd2;
	localparam logic [3:0] S_SCAN_CMP = 4'd3;
	localparam logic [3:0] S_INS_RD   = 4'd4;
	localparam logic [3:0] S_INS_WR   = 4'd5;
	localparam logic [3:0] S_DEL_RD   = 4'd6;
	localparam logic [3:0] S_DEL_WR   = 4'd7;
	localparam logic [3:0] S_DUMP_RD  = 4'd8;
	localparam logic [3:0] S_DUMP_OUT = 4'd9;

	logic [3:0]                 state_q, state_d;
	sle_pkg::op_t               op_q, op_d;
	logic [sle_pkg::ValueW-1:0] val_q, val_d;
	logic [CW-1:0]              idx_q, idx_d;
	logic [CW-1:0]              k_q, k_d;
	logic [CW-1:0]              count_q, count_d;
	sle_pkg::status_t           res_q, res_d;

	logic                       rsp_valid_q;
	sle_pkg::status_t           rsp_status_q;
	logic [sle_pkg::ValueW-1:0] rsp_value_q;
	logic                       rsp_last_q;
	logic [CntOutW-1:0]         rsp_count_q;

	logic                       load_out;
	sle_pkg::status_t           out_status;
	logic [sle_pkg::ValueW-1:0] out_value;
	logic                       out_last;

	logic          out_free;
	logic          full;
	logic          empty;
	logic [CW-1:0] idx_next;
	logic          last_idx;
	logic [CW-1:0] km1;
	logic [CW-1:0] kp1;
	logic          v_lt_d;
	logic          d_lt_v;
	logic          found_ins;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign idx_next  = idx_q + CW'(1);
	assign last_idx  = (idx_next == count_q);
	assign km1       = k_q - CW'(1);
	assign kp1       = k_q + CW'(1);
	assign v_lt_d    = $signed(val_q) < $signed(mem_rd_data);
	assign d_lt_v    = $signed(mem_rd_data) < $signed(val_q);
	// head: insert in front if value is smaller; later: stop at first entry not smaller
	assign found_ins = (idx_q == '0) ? v_lt_d : !d_lt_v;

	assign cmd.ready = (state_q == S_IDLE);

	// Next-state and memory access logic
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		val_d       = val_q;
		idx_d       = idx_q;
		k_d         = k_q;
		count_d     = count_q;
		res_d       = res_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = k_q[AW-1:0];
		mem_wr_data = val_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = idx_q[AW-1:0];
		load_out    = 1'b0;
		out_status  = res_q;
		out_value   = val_q;
		out_last    = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					op_d  = cmd.operation;
					val_d = cmd.value;
					idx_d = '0;
					res_d = sle_pkg::StOk;
					unique case (cmd.operation)
						sle_pkg::OpInsert, sle_pkg::OpAppend: begin
							priority if (full) begin
								res_d   = sle_pkg::StFull;
								state_d = S_RESULT;
							end else if (cmd.operation == sle_pkg::OpAppend || empty) begin
								mem_wr_en   = 1'b1;
								mem_wr_addr = count_q[AW-1:0];
								mem_wr_data = cmd.value;
								count_d     = count_q + CW'(1);
								state_d     = S_RESULT;
							end else begin
								state_d = S_SCAN_RD;
							end
						end
						sle_pkg::OpDelete: begin
							if (empty) begin
								res_d   = sle_pkg::StNotFound;
								state_d = S_RESULT;
							end else begin
								state_d = S_SCAN_RD;
							end
						end
						sle_pkg::OpDump: begin
							if (empty) begin
								res_d   = sle_pkg::StEmpty;
								val_d   = '0;
								state_d = S_RESULT;
							end else begin
								state_d = S_DUMP_RD;
							end
						end
					endcase
				end
			end
			S_RESULT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN_RD: begin
				mem_rd_en = 1'b1;
				state_d   = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (op_q == sle_pkg::OpInsert) begin
					// idx holds the insert position once found
					priority if (found_ins) begin
						k_d     = count_q;
						state_d = S_INS_RD;
					end else if (last_idx) begin
						idx_d   = idx_next;
						k_d     = count_q;
						state_d = S_INS_RD;
					end else begin
						idx_d   = idx_next;
						state_d = S_SCAN_RD;
					end
				end else begin
					priority if (mem_rd_data == val_q) begin
						k_d     = idx_q;
						state_d = S_DEL_RD;
					end else if (last_idx) begin
						res_d   = sle_pkg::StNotFound;
						state_d = S_RESULT;
					end else begin
						idx_d   = idx_next;
						state_d = S_SCAN_RD;
					end
				end
			end
			// open a slot: move entries up from the tail down to the position
			S_INS_RD: begin
				if (k_q == idx_q) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = k_q[AW-1:0];
					mem_wr_data = val_q;
					count_d     = count_q + CW'(1);
					state_d     = S_RESULT;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = km1[AW-1:0];
					state_d     = S_INS_WR;
				end
			end
			S_INS_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = k_q[AW-1:0];
				mem_wr_data = mem_rd_data;
				k_d         = km1;
				state_d     = S_INS_RD;
			end
			// close a slot: move entries down from the position to the tail
			S_DEL_RD: begin
				if (kp1 == count_q) begin
					count_d = count_q - CW'(1);
					state_d = S_RESULT;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = kp1[AW-1:0];
					state_d     = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = k_q[AW-1:0];
				mem_wr_data = mem_rd_data;
				k_d         = kp1;
				state_d     = S_DEL_RD;
			end
			S_DUMP_RD: begin
				mem_rd_en = 1'b1;
				state_d   = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				// read data holds until the next read, so it can wait on the output
				if (out_free) begin
					load_out   = 1'b1;
					out_status = sle_pkg::StOk;
					out_value  = mem_rd_data;
					out_last   = last_idx;
					if (last_idx) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_next;
						state_d = S_DUMP_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Working registers of the current item
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		val_q <= val_d;
		idx_q <= idx_d;
		k_q   <= k_d;
		res_q <= res_d;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_status_q <= out_status;
			rsp_value_q  <= out_value;
			rsp_last_q   <= out_last;
			rsp_count_q  <= CntOutW'(count_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_value = rsp_value_q;
	assign rsp.is_last     = rsp_last_q;
	assign rsp.entry_count = rsp_count_q;

endmodule

@@ src/sorted_list_engine_top.sv @@
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words held in a single-port-read,
// single-port-write RAM with registered read data. Commands: insert sorted,
// append, delete first equal, dump. Everything runs through one sequencer that
// makes one memory access per step: append and any refused or empty-list case
// go straight to the result; insert scans entries for the position, then moves
// the entries behind it up one slot; delete scans for a match, then moves the
// entries behind it down one slot, or reports no match after the scan; dump
// reads and outputs each entry in turn. Entries scanned plus entries moved never
// exceed CAPACITY. An item also waits while the output is stalled. A new command is
// taken only once the previous one has placed its last result in the output
// register; that register lets the next command start while the result waits.
module sorted_list_engine_top #(
	parameter int CAPACITY = sle_pkg::Capacity
) (
	input logic       clk,
	input logic       arst_n,
	sle_cmd_if.sink   cmd,
	sle_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic                       mem_wr_en;
	logic [AW-1:0]              mem_wr_addr;
	logic [sle_pkg::ValueW-1:0] mem_wr_data;
	logic                       mem_rd_en;
	logic [AW-1:0]              mem_rd_addr;
	logic [sle_pkg::ValueW-1:0] mem_rd_data;

	sle_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	sle_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(sle_pkg::ValueW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

endmodule

@@ src/sle_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks on the list engine
module sle_checker #(
	parameter int CAPACITY = sle_pkg::Capacity
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [sle_pkg::StatusW-1:0] rsp_status,
	input logic [sle_pkg::ValueW-1:0]  rsp_entry_value,
	input logic                        rsp_is_last,
	input logic [sle_pkg::CountW-1:0]  rsp_entry_count
);

	localparam int CntW = sle_pkg::CountW;

	// A held result keeps its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
		&& $stable({rsp_status, rsp_entry_value, rsp_is_last, rsp_entry_count}))
		else $error("response changed while stalled");

	// The engine is busy in the cycle after it takes a command
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

	// Empty dump reports a single zero item
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == sle_pkg::StEmpty |->
		rsp_entry_count == '0 && rsp_is_last && rsp_entry_value == '0)
		else $error("bad empty-list result");

	// A refused insert or append sees a full list
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == sle_pkg::StFull |->
		rsp_entry_count == CntW'(CAPACITY) && rsp_is_last)
		else $error("full status with list not full");

endmodule

bind sorted_list_engine_top sle_checker #(
	.CAPACITY(CAPACITY)
) u_sle_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_entry_value(rsp.entry_value),
	.rsp_is_last    (rsp.is_last),
	.rsp_entry_count(rsp.entry_count)
);
